@@ rtl/assert_macros.svh @@
// Assertion helpers for the walk counter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a must imply b on the next cycle
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

// property a must imply b in the same cycle
`define ASSERT_SAME(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

`endif

@@ rtl/bwc_pkg.sv @@
package bwc_pkg;
  localparam int DIM_LG = 4;
  localparam int DIM = 1 << DIM_LG;
  localparam int EXP_BITS = 60;
  localparam int VAL_W = 30;
  localparam int ADDR_W = 2 * DIM_LG;
  localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // which product the multiply engine runs
  typedef enum logic [1:0] {
    OP_RES = 2'b01,   // result * power -> result
    OP_SQR = 2'b10    // power * power -> power
  } op_t;

  typedef struct packed {
    logic go;
    op_t  op;
  } mm_cmd_t;

  // modular add of two reduced values
  function automatic val_t mod_add(val_t a, val_t b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) s = s - {1'b0, MODULUS};
    return s[VAL_W-1:0];
  endfunction
endpackage

@@ rtl/bounded_walk_count_matrix_power.sv @@
// Bounded walk counter, modulo 1000000007.
// Input channel (in_valid/in_ready): one request per segment with
// in_start_new, in_segment_start, in_segment_end, in_segment_ceiling.
// Output channel (out_valid/out_ready): one out_walks_to_ground per request,
// the (0,0) entry of the kept 16x16 result matrix.
// cfg_we/cfg_wdata write target_x; the user must write it only while idle, which the block itself does not enforce.
// Work per request: the result matrix is reset to the identity when
// in_start_new is set, the step matrix is built, then matrix products run,
// each of 4096 MAC issues, the multiplier pipeline and a copy out of
// scratch. An exponent of e bits costs up to 2e-1 products; the single
// modular MAC unit and its memory port set the run time.
// One request is processed at a time. A finished result sits in an output
// register; the next request is accepted while it waits to be taken, and
// its processing then stalls only at its own result until out_ready.
// Reset (synchronous, rst_n low) clears target_x and makes the result
// matrix the identity over a sweep of its entries, during which in_ready is low.
`include "assert_macros.svh"
module bounded_walk_count_matrix_power (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_new,
  input  logic [59:0] in_segment_start,
  input  logic [59:0] in_segment_end,
  input  logic [3:0]  in_segment_ceiling,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] out_walks_to_ground,
  input  logic        cfg_we,
  input  logic [59:0] cfg_wdata
);
  import bwc_pkg::*;

  typedef enum logic [6:0] {
    C_RST   = 7'b0000001,
    C_IDLE  = 7'b0000010,
    C_INIT  = 7'b0000100,
    C_BUILD = 7'b0001000,
    C_STEP  = 7'b0010000,
    C_WAIT  = 7'b0100000,
    C_OUT   = 7'b1000000
  } ctl_t;

  ctl_t st_r, st_nxt;
  logic [EXP_BITS-1:0] tgt_r, exp_r, exp_nxt;
  logic fresh_r;
  logic [3:0] ceil_r;
  logic [EXP_BITS-1:0] lo_r, hi_r;
  logic sq_r, sq_nxt;            // next product is a squaring
  logic ovld_r;
  val_t odat_r;
  logic mm_busy, kick;
  val_t res00;
  mm_cmd_t cmd;
  logic init_go, build_go;

  bwc_matmul u_mat (
    .clk(clk), .rst_n(rst_n), .init(init_go), .build(build_go),
    .ceil_y(ceil_r), .cmd(cmd), .busy(mm_busy), .res00(res00)
  );

  assign in_ready = (st_r == C_IDLE);

  logic [EXP_BITS-1:0] stop;
  assign stop = (hi_r < tgt_r) ? hi_r : tgt_r;

  always_comb begin
    st_nxt = st_r;
    exp_nxt = exp_r;
    sq_nxt = sq_r;
    init_go = 1'b0;
    build_go = 1'b0;
    cmd = '{go: 1'b0, op: OP_RES};
    kick = 1'b0;
    unique case (st_r)
      C_RST: begin
        init_go = 1'b1;
        st_nxt = C_WAIT;
        exp_nxt = '0;
      end
      C_IDLE: if (in_valid) st_nxt = C_INIT;
      C_INIT: begin
        init_go = fresh_r;
        if (!fresh_r) st_nxt = C_BUILD;
        else st_nxt = C_BUILD;
        exp_nxt = (stop >= lo_r) ? stop - lo_r : '0;
        sq_nxt = 1'b0;
      end
      C_BUILD: if (!mm_busy) begin
        build_go = 1'b1;
        st_nxt = C_STEP;
      end
      C_STEP: if (!mm_busy) begin
        if (exp_r == '0) st_nxt = C_OUT;
        else if (sq_r) begin
          cmd = '{go: 1'b1, op: OP_SQR};
          sq_nxt = 1'b0;
        end else begin
          if (exp_r[0]) cmd = '{go: 1'b1, op: OP_RES};
          exp_nxt = exp_r >> 1;
          sq_nxt = (exp_r >> 1) != '0;
        end
      end
      C_WAIT: if (!mm_busy) st_nxt = C_IDLE;
      C_OUT: if (!ovld_r || out_ready) begin
        kick = 1'b1;
        st_nxt = C_IDLE;
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_RST;
      tgt_r <= '0;
      exp_r <= '0;
      sq_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      exp_r <= exp_nxt;
      sq_r <= sq_nxt;
      if (cfg_we) tgt_r <= cfg_wdata;
      if (kick) ovld_r <= 1'b1;
      else if (out_ready) ovld_r <= 1'b0;
    end
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fresh_r <= in_start_new;
      lo_r <= in_segment_start;
      hi_r <= in_segment_end;
      ceil_r <= in_segment_ceiling;
    end
    if (kick) odat_r <= res00;
  end

  assign out_valid = ovld_r;
  assign out_walks_to_ground = odat_r;

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_walks_to_ground))
  `ASSERT_SAME(a_no_accept_busy, in_valid && in_ready, !mm_busy)
  `ASSERT_SAME(a_kick_free, kick, !ovld_r || out_ready)
endmodule

@@ rtl/bwc_modmul.sv @@
// Pipelined a*b mod p: multiply, then reduce by repeated halving in stages.
module bwc_modmul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  bwc_pkg::val_t a,
  input  bwc_pkg::val_t b,
  output logic          out_vld,
  output bwc_pkg::val_t prod
);
  import bwc_pkg::*;

  localparam int PW = 2 * VAL_W;
  localparam int NST = VAL_W + 1;

  logic [PW-1:0] p_r [NST+1];
  logic [NST:0]  v_r;

  // stage 0: raw product
  always_ff @(posedge clk) begin
    p_r[0] <= {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b};
  end

  // each stage subtracts p shifted left by SH when it fits, SH from 30 down to 0
  for (genvar s = 0; s < NST; s++) begin : g_red
    localparam int SH = NST - 1 - s;
    logic [PW+1:0] sub;
    assign sub = {2'b00, {{VAL_W{1'b0}}, MODULUS}} << SH;
    always_ff @(posedge clk) begin
      if ({2'b00, p_r[s]} >= sub) p_r[s+1] <= PW'({2'b00, p_r[s]} - sub);
      else p_r[s+1] <= p_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[NST-1:0], in_vld};
  end

  assign out_vld = v_r[NST];
  assign prod = p_r[NST][VAL_W-1:0];
endmodule

@@ rtl/bwc_matmul.sv @@
// Matrix engine: holds result and power stores, resets result to identity, builds step matrix, runs products.
// One MAC term issued per cycle; a row-column sum is accumulated as terms return.
module bwc_matmul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            init,        // reset result to identity (sweep)
  input  logic            build,       // build step matrix
  input  logic [3:0]      ceil_y,
  input  bwc_pkg::mm_cmd_t cmd,
  output logic            busy,
  output bwc_pkg::val_t   res00
);
  import bwc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FILL  = 5'b00010,
    S_MUL   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_COPY  = 5'b10000
  } st_t;

  val_t res_mem [DIM*DIM];
  val_t pow_mem [DIM*DIM];
  val_t scr_mem [DIM*DIM];

  st_t st_r, st_nxt;
  logic fill_res_r, fill_res_nxt;
  op_t op_r;
  logic [3:0] ceil_r;
  logic [ADDR_W+DIM_LG:0] cnt_r, cnt_nxt;     // issue counter r,c,t
  logic [ADDR_W:0] wcnt_r;                    // result-write counter
  logic [DIM_LG-1:0] tcnt_r;                   // term count of current sum
  val_t acc_r;
  val_t res00_r;
  val_t scr_q;                                 // scratch read data
  addr_t cp_addr;                              // copy write address, one behind

  logic [DIM_LG-1:0] ir, ic, it;
  assign ir = cnt_r[ADDR_W+DIM_LG-1 -: DIM_LG];
  assign ic = cnt_r[ADDR_W-1 -: DIM_LG];
  assign it = cnt_r[DIM_LG-1:0];
  assign cp_addr = cnt_r[ADDR_W-1:0] - 1'b1;

  // read ports, data registered
  val_t lhs_q, rhs_q, res_q, pow_q;
  logic rd_vld_r;
  always_ff @(posedge clk) begin
    res_q <= res_mem[{ir, it}];
    pow_q <= pow_mem[{it, ic}];
    lhs_q <= pow_mem[{ir, it}];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else rd_vld_r <= (st_r == S_MUL);
  end
  assign rhs_q = pow_q;

  // scratch read port for the copy pass
  always_ff @(posedge clk) begin
    scr_q <= scr_mem[cnt_r[ADDR_W-1:0]];
  end

  logic mvld;
  val_t mprod;
  bwc_modmul u_mm (
    .clk(clk), .rst_n(rst_n), .in_vld(rd_vld_r),
    .a(op_r == OP_RES ? res_q : lhs_q), .b(rhs_q),
    .out_vld(mvld), .prod(mprod)
  );

  // step matrix entry at fill address
  logic [DIM_LG-1:0] fr, fc;
  logic fin, fstep;
  assign fr = cnt_r[ADDR_W-1 -: DIM_LG];
  assign fc = cnt_r[DIM_LG-1:0];
  assign fin = ({1'b0, fr} <= {1'b0, ceil_r}) && ({1'b0, fc} <= {1'b0, ceil_r});
  assign fstep = (fr == fc) || (fr == fc + 1'b1 && fc != '1) || (fc == fr + 1'b1 && fr != '1);

  // stores
  val_t acc_sum;
  assign acc_sum = mod_add(tcnt_r == '0 ? '0 : acc_r, mprod);
  always_ff @(posedge clk) begin
    if (st_r == S_FILL) begin
      if (fill_res_r) res_mem[cnt_r[ADDR_W-1:0]] <= (fr == fc) ? val_t'(1) : '0;
      else pow_mem[cnt_r[ADDR_W-1:0]] <= (fin && fstep) ? val_t'(1) : '0;
    end
    if (mvld && tcnt_r == '1) scr_mem[wcnt_r[ADDR_W-1:0]] <= acc_sum;
    // copy writes each scratch entry in the cycle after it is read
    if (st_r == S_COPY && cnt_r != '0) begin
      if (op_r == OP_RES) res_mem[cp_addr] <= scr_q;
      else pow_mem[cp_addr] <= scr_q;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcnt_r <= '0;
      wcnt_r <= '0;
    end else if (st_r == S_IDLE) begin
      tcnt_r <= '0;
      wcnt_r <= '0;
    end else if (mvld) begin
      acc_r <= acc_sum;
      tcnt_r <= tcnt_r + 1'b1;
      if (tcnt_r == '1) wcnt_r <= wcnt_r + 1'b1;
    end
  end

  // track (0,0) of result
  always_ff @(posedge clk) begin
    if (!rst_n) res00_r <= val_t'(1);
    else if (st_r == S_FILL && fill_res_r && cnt_r[ADDR_W-1:0] == '0) res00_r <= val_t'(1);
    else if (st_r == S_COPY && op_r == OP_RES && cp_addr == '0)
      res00_r <= scr_q;
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    fill_res_nxt = fill_res_r;
    unique case (st_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (init) begin
          st_nxt = S_FILL;
          fill_res_nxt = 1'b1;
        end else if (build) begin
          st_nxt = S_FILL;
          fill_res_nxt = 1'b0;
        end else if (cmd.go) st_nxt = S_MUL;
      end
      S_FILL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[ADDR_W-1:0] == '1) st_nxt = S_IDLE;
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[ADDR_W+DIM_LG-1:0] == '1) st_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cnt_nxt = '0;
        if (wcnt_r[ADDR_W]) st_nxt = S_COPY;
      end
      S_COPY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[ADDR_W]) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      fill_res_r <= 1'b0;
      op_r <= OP_RES;
      ceil_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      fill_res_r <= fill_res_nxt;
      if (st_r == S_IDLE && cmd.go) op_r <= cmd.op;
      if (st_r == S_IDLE && build) ceil_r <= ceil_y;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign res00 = res00_r;
endmodule
